### rtl/srfc_pkg.sv
// ----------------------------------------------------------------------------
// Scan response frame checker package
// Shared types, frame constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int SERIAL_BYTES_DEF    = 4;
    localparam int MAX_FRAME_BYTES_DEF = 32;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] SCAN_ADDRESS  = 8'hFD;
    localparam logic [7:0] SCAN_COMMAND  = 8'h60;
    localparam logic [7:0] SUB_DATA      = 8'h03;
    localparam logic [7:0] SUB_END       = 8'h04;

    // Shortest body that can hold a header and a CRC.
    localparam int MIN_BODY = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_DATA       = 3'd0,
        ST_END        = 3'd1,
        ST_BAD_SUB    = 3'd2,
        ST_CRC_ERR    = 3'd3,
        ST_BAD_HEADER = 3'd4,
        ST_OVERFLOW   = 3'd5,
        ST_SHORT      = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] serial_number;
        logic [7:0]  device_address;
    } result_item_t;

    // Reflected CRC-16/MODBUS update over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/srfc_track.sv
// ----------------------------------------------------------------------------
// Scan response frame tracker
// Holds the per-frame state, updates it with each byte and classifies the
// frame on its last byte.
// ----------------------------------------------------------------------------
module srfc_track #(
    parameter int SERIAL_BYTES    = srfc_pkg::SERIAL_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = srfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  srfc_pkg::byte_item_t   item,
    output srfc_pkg::result_item_t result
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] MAX_C      = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] HDR_END    = CW'(3);
    localparam logic [CW-1:0] ADDR_POS   = CW'(3 + SERIAL_BYTES);
    localparam logic [CW-1:0] MIN_C      = CW'(srfc_pkg::MIN_BODY);
    localparam logic [CW-1:0] DATA_MIN_C = CW'(SERIAL_BYTES + 6);

    logic [CW-1:0] raw_count_reg,  raw_count_next;
    logic [CW-1:0] body_count_reg, body_count_next;
    logic          overflowed_reg, overflowed_next;
    logic          in_preamble_reg, in_preamble_next;
    logic [15:0]   crc_reg, crc_next;
    logic [31:0]   serial_reg, serial_next;
    logic [7:0]    address_reg, address_next;
    logic [7:0]    header_reg [3];

    logic          hdr_we;
    logic [1:0]    hdr_idx;
    logic [7:0]    b;
    logic          last_byte;
    srfc_pkg::status_t status;

    assign b         = item.data_byte;
    assign last_byte = fire && item.frame_end;
    assign hdr_idx   = body_count_reg[1:0];

    always_comb
    begin
        raw_count_next   = raw_count_reg;
        body_count_next  = body_count_reg;
        overflowed_next  = overflowed_reg;
        in_preamble_next = in_preamble_reg;
        crc_next         = crc_reg;
        serial_next      = serial_reg;
        address_next     = address_reg;
        hdr_we           = 1'b0;
        if (raw_count_reg >= MAX_C)
        begin
            overflowed_next = 1'b1;
        end
        else
        begin
            raw_count_next = raw_count_reg + CW'(1);
            if (!(in_preamble_reg && b == srfc_pkg::PREAMBLE_BYTE))
            begin
                in_preamble_next = 1'b0;
                body_count_next  = body_count_reg + CW'(1);
                crc_next         = srfc_pkg::crc_byte(crc_reg, b);
                if (body_count_reg < HDR_END)
                begin
                    hdr_we = 1'b1;
                end
                else if (body_count_reg < ADDR_POS)
                begin
                    serial_next = {serial_reg[23:0], b};
                end
                else if (body_count_reg == ADDR_POS)
                begin
                    address_next = b;
                end
            end
        end
    end

    // The header bytes are read only when the body is long enough to have
    // written all three, so they need no clearing. The byte written on the
    // last item itself is taken from the bus rather than the register.
    logic [7:0] hdr0, hdr1, hdr2;
    assign hdr0 = (hdr_we && hdr_idx == 2'd0) ? b : header_reg[0];
    assign hdr1 = (hdr_we && hdr_idx == 2'd1) ? b : header_reg[1];
    assign hdr2 = (hdr_we && hdr_idx == 2'd2) ? b : header_reg[2];

    always_comb
    begin
        priority if (overflowed_next)
        begin
            status = srfc_pkg::ST_OVERFLOW;
        end
        else if (body_count_next < MIN_C)
        begin
            status = srfc_pkg::ST_SHORT;
        end
        else if (crc_next != 16'h0000)
        begin
            status = srfc_pkg::ST_CRC_ERR;
        end
        else if (hdr0 != srfc_pkg::SCAN_ADDRESS || hdr1 != srfc_pkg::SCAN_COMMAND)
        begin
            status = srfc_pkg::ST_BAD_HEADER;
        end
        else if (hdr2 == srfc_pkg::SUB_END)
        begin
            status = srfc_pkg::ST_END;
        end
        else if (hdr2 != srfc_pkg::SUB_DATA)
        begin
            status = srfc_pkg::ST_BAD_SUB;
        end
        else if (body_count_next < DATA_MIN_C)
        begin
            status = srfc_pkg::ST_SHORT;
        end
        else
        begin
            status = srfc_pkg::ST_DATA;
        end
    end

    always_comb
    begin
        result.status         = status;
        result.serial_number  = 32'h0;
        result.device_address = 8'h00;
        if (status == srfc_pkg::ST_DATA)
        begin
            result.serial_number  = serial_next;
            result.device_address = address_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_count_reg   <= '0;
            body_count_reg  <= '0;
            overflowed_reg  <= 1'b0;
            in_preamble_reg <= 1'b1;
            crc_reg         <= srfc_pkg::CRC_INIT;
            serial_reg      <= 32'h0;
            address_reg     <= 8'h00;
        end
        else if (last_byte)
        begin
            raw_count_reg   <= '0;
            body_count_reg  <= '0;
            overflowed_reg  <= 1'b0;
            in_preamble_reg <= 1'b1;
            crc_reg         <= srfc_pkg::CRC_INIT;
            serial_reg      <= 32'h0;
            address_reg     <= 8'h00;
        end
        else if (fire)
        begin
            raw_count_reg   <= raw_count_next;
            body_count_reg  <= body_count_next;
            overflowed_reg  <= overflowed_next;
            in_preamble_reg <= in_preamble_next;
            crc_reg         <= crc_next;
            serial_reg      <= serial_next;
            address_reg     <= address_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hdr_we)
        begin
            header_reg[hdr_idx] <= b;
        end
    end

endmodule

### rtl/scan_response_frame_checker_core.sv
// ----------------------------------------------------------------------------
// Scan response frame checker core
// Checks received bus-scan response frames byte by byte and reports one
// status item per frame.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_item) carries one received
//   byte per item; frame_end marks the last byte of a frame. Leading 0xFF
//   bytes are skipped and CRC-16/MODBUS runs over the rest, CRC included.
//   The result channel (result_valid, result_stall, result_item) carries one
//   item per frame: status, serial number and device address, the latter two
//   zero unless the status is device data.
//   Each byte goes into an input register and is processed from there; a
//   frame's result is loaded into the result register when its last byte
//   is processed. One byte is taken every cycle while the result side
//   keeps up. Reset clears the frame state to the start of a preamble and
//   empties both registers. While result_stall holds a result, bytes that
//   produce no result keep flowing; a second frame end waits in the input
//   register and byte_stall rises until the pending result is taken.
// ----------------------------------------------------------------------------
module scan_response_frame_checker_core #(
    parameter int SERIAL_BYTES    = srfc_pkg::SERIAL_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = srfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  srfc_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output srfc_pkg::result_item_t result_item
);

    logic                   in_valid_reg, in_valid_next;
    srfc_pkg::byte_item_t   in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    srfc_pkg::result_item_t out_item_reg;
    srfc_pkg::result_item_t result;
    logic                   accept;
    logic                   fire;
    logic                   out_load;

    // A byte without a frame end never needs the result register.
    assign fire       = in_valid_reg
                        && (!in_item_reg.frame_end || !out_valid_reg || !result_stall);
    assign out_load   = fire && in_item_reg.frame_end;
    assign byte_stall = in_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;

    assign in_valid_next  = accept || (in_valid_reg && !fire);
    assign out_valid_next = out_load || (out_valid_reg && result_stall);

    srfc_track #(
        .SERIAL_BYTES    (SERIAL_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_item;
        end
        if (out_load)
        begin
            out_item_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg && in_item_reg.frame_end && out_valid_reg)
        else $error("byte_stall raised without a blocked frame end");

    a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(result_valid)) |-> $past(out_load))
        else $error("result appeared without a frame end");

    a_no_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.status != srfc_pkg::ST_DATA)
        |-> (result_item.serial_number == 32'h0 && result_item.device_address == 8'h00))
        else $error("serial or address set on a non-data status");
`endif

endmodule

### tb/tb_scan_response_frame_checker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan response frame checker core testbench
// Sends response frames byte by byte with random gaps and result stalls, and
// predicts each frame's status, serial number and device address in the
// bench. Every result item is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_scan_response_frame_checker_core;

    typedef logic [7:0] octet_t;

    localparam int SERIAL_BYTES    = srfc_pkg::SERIAL_BYTES_DEF;
    localparam int MAX_FRAME_BYTES = srfc_pkg::MAX_FRAME_BYTES_DEF;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_BYTES    = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   byte_valid = 1'b0;
    logic                   byte_stall;
    srfc_pkg::byte_item_t   byte_item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    srfc_pkg::result_item_t result_item;

    scan_response_frame_checker_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #5 clk = ~clk;

    srfc_pkg::byte_item_t   pending_bytes[$];
    srfc_pkg::result_item_t expected_reports[$];
    srfc_pkg::result_item_t oldest_report;
    int           total_bytes;
    int           bytes_accepted = 0;
    int           error_count = 0;
    int           idle_cycles = 0;
    logic         byte_taken = 1'b0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           send_calm = 1'b0;
    bit           stall_calm = 1'b0;

    // Frame state of the predictor.
    logic [5:0]  frame_bytes;
    logic        overrun;
    logic        skipping_preamble;
    logic [5:0]  body_len;
    logic [15:0] crc_acc;
    octet_t      hdr[3];
    logic [31:0] serial_acc;
    octet_t      addr_acc;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input octet_t b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
        end
        return acc;
    endfunction

    // Mostly short idle runs with an occasional long one.
    function automatic int pick_idle_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic clear_frame_state();
        frame_bytes       = '0;
        overrun           = 1'b0;
        skipping_preamble = 1'b1;
        body_len          = '0;
        crc_acc           = 16'hFFFF;
        hdr[0]            = '0;
        hdr[1]            = '0;
        hdr[2]            = '0;
        serial_acc        = '0;
        addr_acc          = '0;
    endtask

    task automatic predict_byte(input srfc_pkg::byte_item_t it);
        srfc_pkg::result_item_t rep;
        if (frame_bytes >= MAX_FRAME_BYTES)
        begin
            overrun = 1'b1;
        end
        else
        begin
            frame_bytes++;
            if (!(skipping_preamble && it.data_byte == srfc_pkg::PREAMBLE_BYTE))
            begin
                skipping_preamble = 1'b0;
                if (body_len < 3)
                begin
                    hdr[body_len] = it.data_byte;
                end
                else if (body_len < 3 + SERIAL_BYTES)
                begin
                    serial_acc = {serial_acc[23:0], it.data_byte};
                end
                else if (body_len == 3 + SERIAL_BYTES)
                begin
                    addr_acc = it.data_byte;
                end
                body_len++;
                crc_acc = crc16_step(crc_acc, it.data_byte);
            end
        end
        if (it.frame_end)
        begin
            rep = '0;
            if (overrun)
            begin
                rep.status = srfc_pkg::ST_OVERFLOW;
            end
            else if (body_len < srfc_pkg::MIN_BODY)
            begin
                rep.status = srfc_pkg::ST_SHORT;
            end
            else if (crc_acc != 16'h0000)
            begin
                rep.status = srfc_pkg::ST_CRC_ERR;
            end
            else if (hdr[0] != srfc_pkg::SCAN_ADDRESS || hdr[1] != srfc_pkg::SCAN_COMMAND)
            begin
                rep.status = srfc_pkg::ST_BAD_HEADER;
            end
            else if (hdr[2] == srfc_pkg::SUB_END)
            begin
                rep.status = srfc_pkg::ST_END;
            end
            else if (hdr[2] != srfc_pkg::SUB_DATA)
            begin
                rep.status = srfc_pkg::ST_BAD_SUB;
            end
            else if (body_len < SERIAL_BYTES + 6)
            begin
                rep.status = srfc_pkg::ST_SHORT;
            end
            else
            begin
                rep.status         = srfc_pkg::ST_DATA;
                rep.serial_number  = serial_acc;
                rep.device_address = addr_acc;
            end
            expected_reports.push_back(rep);
            clear_frame_state();
        end
    endtask

    // Queues preamble bytes, the body and, if asked, its CRC low byte first.
    task automatic queue_frame(input int n_pre, input octet_t body[$], input bit add_crc);
        logic [15:0]          crc;
        octet_t               all_bytes[$];
        srfc_pkg::byte_item_t it;
        crc = 16'hFFFF;
        for (int i = 0; i < n_pre; i++)
        begin
            all_bytes.push_back(srfc_pkg::PREAMBLE_BYTE);
        end
        foreach (body[i])
        begin
            crc = crc16_step(crc, body[i]);
            all_bytes.push_back(body[i]);
        end
        if (add_crc)
        begin
            all_bytes.push_back(crc[7:0]);
            all_bytes.push_back(crc[15:8]);
        end
        foreach (all_bytes[i])
        begin
            it.data_byte = all_bytes[i];
            it.frame_end = (i == all_bytes.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic add_data_body(ref octet_t body[$]);
        body.push_back(srfc_pkg::SCAN_ADDRESS);
        body.push_back(srfc_pkg::SCAN_COMMAND);
        body.push_back(srfc_pkg::SUB_DATA);
        for (int i = 0; i < SERIAL_BYTES + 1; i++)
        begin
            body.push_back(octet_t'($urandom_range(0, 255)));
        end
    endtask

    // Driver: new byte items change at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_taken)
            begin
                // A stalled item holds its payload.
            end
            else if (gap_left > 0)
            begin
                byte_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (pending_bytes.size() > 0)
            begin
                byte_item  <= pending_bytes.pop_front();
                byte_valid <= 1'b1;
                gap_left   <= send_calm ? 0 : pick_idle_run();
                if ($urandom_range(0, 59) == 0)
                begin
                    send_calm <= !send_calm;
                end
            end
            else
            begin
                byte_valid <= 1'b0;
            end

            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (!stall_calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left <= pick_idle_run();
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                stall_calm <= !stall_calm;
            end
        end
    end

    // Monitor and watchdog, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, result_item.status);
                    error_count++;
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    if (result_item.status !== oldest_report.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, oldest_report.status, result_item.status);
                        error_count++;
                    end
                    if (result_item.serial_number !== oldest_report.serial_number)
                    begin
                        $display("%0t: serial_number mismatch, expected %h, got %h",
                                 $time, oldest_report.serial_number,
                                 result_item.serial_number);
                        error_count++;
                    end
                    if (result_item.device_address !== oldest_report.device_address)
                    begin
                        $display("%0t: device_address mismatch, expected %h, got %h",
                                 $time, oldest_report.device_address,
                                 result_item.device_address);
                        error_count++;
                    end
                end
            end
            if (byte_valid && !byte_stall)
            begin
                predict_byte(byte_item);
                bytes_accepted++;
            end
            if ((result_valid && !result_stall) || (byte_valid && !byte_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            byte_taken <= byte_valid && !byte_stall;
        end
    end

    initial
    begin
        octet_t body[$];
        int     kind;
        int     n_pre;
        int     idx;
        int     target;

        clear_frame_state();

        // Good data frame with a preamble and extreme serial and address bytes.
        body = '{srfc_pkg::SCAN_ADDRESS, srfc_pkg::SCAN_COMMAND, srfc_pkg::SUB_DATA,
                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        queue_frame(2, body, 1'b1);
        // End of scan.
        body = '{srfc_pkg::SCAN_ADDRESS, srfc_pkg::SCAN_COMMAND, srfc_pkg::SUB_END};
        queue_frame(0, body, 1'b1);
        // One-byte frame, then a frame of preamble only.
        body = '{8'h00};
        queue_frame(0, body, 1'b0);
        body.delete();
        queue_frame(1, body, 1'b0);
        // Data subcommand with a valid CRC but no serial bytes.
        body = '{srfc_pkg::SCAN_ADDRESS, srfc_pkg::SCAN_COMMAND, srfc_pkg::SUB_DATA};
        queue_frame(0, body, 1'b1);

        while (pending_bytes.size() < 25 + RANDOM_BYTES)
        begin
            body.delete();
            kind  = $urandom_range(0, 99);
            n_pre = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            if (kind < 40)
            begin
                add_data_body(body);
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 3)) body.push_back(octet_t'($urandom));
                end
                queue_frame(n_pre, body, 1'b1);
            end
            else if (kind < 50)
            begin
                body = '{srfc_pkg::SCAN_ADDRESS, srfc_pkg::SCAN_COMMAND, srfc_pkg::SUB_END};
                repeat ($urandom_range(0, 6)) body.push_back(octet_t'($urandom));
                queue_frame(n_pre, body, 1'b1);
            end
            else if (kind < 57)
            begin
                add_data_body(body);
                do
                begin
                    body[2] = octet_t'($urandom);
                end
                while (body[2] == srfc_pkg::SUB_DATA || body[2] == srfc_pkg::SUB_END);
                queue_frame(n_pre, body, 1'b1);
            end
            else if (kind < 65)
            begin
                add_data_body(body);
                if ($urandom_range(0, 1) == 0)
                begin
                    body[0] = octet_t'($urandom);
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    body[1] = octet_t'($urandom);
                end
                if (body[0] == srfc_pkg::SCAN_ADDRESS && body[1] == srfc_pkg::SCAN_COMMAND)
                begin
                    body[1] = body[1] ^ octet_t'($urandom_range(1, 255));
                end
                queue_frame(n_pre, body, 1'b1);
            end
            else if (kind < 73)
            begin
                // Corrupt one body byte after the CRC is worked out.
                add_data_body(body);
                queue_frame(n_pre, body, 1'b1);
                idx = pending_bytes.size() - 2 - $urandom_range(1, body.size());
                pending_bytes[idx].data_byte =
                    pending_bytes[idx].data_byte ^ octet_t'($urandom_range(1, 255));
            end
            else if (kind < 80)
            begin
                // Frames around the buffer limit, most of them past it.
                n_pre  = $urandom_range(0, 10);
                target = $urandom_range(MAX_FRAME_BYTES - 1, MAX_FRAME_BYTES + 6);
                add_data_body(body);
                while (n_pre + body.size() + 2 < target)
                begin
                    body.push_back(octet_t'($urandom));
                end
                queue_frame(n_pre, body, 1'b1);
            end
            else if (kind < 88)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    body = '{srfc_pkg::SCAN_ADDRESS, srfc_pkg::SCAN_COMMAND,
                             srfc_pkg::SUB_DATA};
                    repeat ($urandom_range(0, SERIAL_BYTES)) body.push_back(octet_t'($urandom));
                    queue_frame(n_pre, body, 1'b1);
                end
                else
                begin
                    repeat ($urandom_range(0, srfc_pkg::MIN_BODY - 1))
                        body.push_back(octet_t'($urandom));
                    if (body.size() == 0 && n_pre == 0)
                    begin
                        n_pre = 1;
                    end
                    queue_frame(n_pre, body, 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 14)) body.push_back(octet_t'($urandom));
                queue_frame(n_pre, body, 1'b0);
            end
        end
        total_bytes = pending_bytes.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_accepted < total_bytes || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
